// ===== design/brd_pkg.sv =====
// Shared types and constants for the bitmap RLE run decoder.
package brd_pkg;

    // Field and state widths fixed by the stream format and the register map.
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 24;
    localparam int DIM_W   = 13;
    localparam int POS_W   = 25;
    localparam int START_W = 24;
    localparam int CFG_IDX_W = 2;

    // Limits on the effective image size.
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;
    localparam logic [DIM_W-1:0] WIDTH_LIM =
        (MAX_WIDTH > 8191) ? 13'h1FFF : DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIM =
        (MAX_HEIGHT > 8191) ? 13'h1FFF : DIM_W'(MAX_HEIGHT);
    localparam logic [POS_W-1:0] TOTAL_CAP = 25'h1000000;

    // Column recompute takes one step per bit of the position.
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Commands.
    localparam logic [CMD_W-1:0] CMD_PAL_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEW_IMAGE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STREAM    = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Escape codes that follow a zero count byte.
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_DELTA_X,
        PH_DELTA_Y,
        PH_LITERAL,
        PH_PAD
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SETTLE,
        ST_DIVIDE
    } t_ctl_state;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BYTE_W-1:0]  palette_index;
        logic [COLOR_W-1:0] palette_color;
        logic [BYTE_W-1:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [START_W-1:0] start_pixel;
        logic [BYTE_W-1:0]  run_length;
        logic [COLOR_W-1:0] color_even;
        logic [COLOR_W-1:0] color_odd;
        logic               image_done;
    } t_out_item;

endpackage

// ===== design/bmp_rle_run_decoder_core.sv =====
// Top level of the bitmap RLE8/RLE4 run decoder.
//
// Input words arrive on a valid/ready channel: palette writes, a start-of-image
// command, and compressed stream bytes. Each stream byte yields at most one
// output word, a run of palette colors at a linear pixel position, on a second
// valid/ready channel. The three registers must be written through a plain
// write port while no word is in flight; the block itself does not enforce this.
// An output word is held first with its palette read and then in the output
// register; a stall at the output can hold it between the two.
// Throughput: one input word per cycle unless the input is held off. When a
// run or a delta carries the column across two or more row starts, the column
// is recomputed by a serial remainder unit, one bit of the position per cycle,
// and the input is held off until it is done. After any register write the
// input is held off while the image size settles and the column is recomputed
// the same way. Reset clears the position, the parser and the output stages;
// palette entries hold nothing useful until written. While the receiver stalls,
// results wait in a two-word output queue; once full, the input is held off.
module bmp_rle_run_decoder_core
    import brd_pkg::*;
#(
    parameter int PAL_DEPTH = PALETTE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int AW = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

    // Registers and derived image size.
    logic             r_mode;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] r_cw;
    logic [POS_W-1:0] r_total;
    logic [DIM_W-1:0] cw_c;
    logic [DIM_W-1:0] ch_c;
    logic [2*DIM_W-1:0] size_prod;
    logic [POS_W-1:0] total_c;

    // Parser state.
    logic [POS_W-1:0]  r_pos;
    logic [DIM_W-1:0]  r_col;
    logic              r_row_end;
    t_phase            r_phase;
    logic [BYTE_W-1:0] r_first;
    logic [BYTE_W-1:0] r_lit;
    logic              r_pad;
    logic [BYTE_W-1:0] r_dcol;
    logic              r_finished;

    logic [POS_W-1:0]  n_pos;
    logic [DIM_W-1:0]  n_col;
    logic              n_row_end;
    t_phase            n_phase;
    logic [BYTE_W-1:0] n_first;
    logic [BYTE_W-1:0] n_lit;
    logic              n_pad;
    logic [BYTE_W-1:0] n_dcol;
    logic              n_finished;

    // Control sequencer and serial remainder unit.
    t_ctl_state           r_state;
    t_ctl_state           n_state;
    logic [POS_W-1:0]     r_div_num;
    logic [DIM_W-1:0]     r_div_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_div_row;
    logic [DIM_W:0]       div_trial;
    logic                 div_ge;
    logic [DIM_W-1:0]     div_rem_next;
    logic                 div_last;
    logic                 run_ok;
    logic                 div_active;
    logic                 div_load_pos;

    // Palette and output stages.
    logic [COLOR_W-1:0] r_pal [PAL_DEPTH];
    logic [AW-1:0]      idx_lut [256];
    logic [COLOR_W-1:0] r_rd0;
    logic [COLOR_W-1:0] r_rd1;
    logic               r_a_valid;
    logic [START_W-1:0] r_a_start;
    logic [BYTE_W-1:0]  r_a_len;
    logic               r_a_done;
    logic               r_a_blank;
    logic               r_a_split;
    logic               r_b_valid;
    t_out_item          r_b_item;
    logic               a_adv;

    // Per-word decode.
    logic              in_fire;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] draw_req;
    logic [BYTE_W-1:0] draw_n;
    logic [POS_W-1:0]  avail;
    logic [POS_W-1:0]  draw_pos;
    logic [DIM_W:0]    col_sum;
    logic [DIM_W:0]    col_diff;
    logic [20:0]       delta_mul;
    logic [POS_W:0]    next_delta;
    logic [POS_W:0]    next_eol;
    logic              pos_at_end;
    logic              draw_do;
    logic              col_fix;
    logic              col_row;
    logic              pal_we;
    logic [AW-1:0]     addr0;
    logic [AW-1:0]     addr1;
    logic              res_valid;
    logic              res_blank;
    logic              res_done;
    logic [BYTE_W-1:0] res_len;
    logic              div_go;
    logic              div_go_row;
    logic [8:0]        lit_plus;

    // Palette index folding, worked out at elaboration.
    for (genvar g = 0; g < 256; g++) begin : g_idx
        assign idx_lut[g] = AW'(g % PAL_DEPTH);
    end

    // ---------------------------------------------------------------
    // Registers and effective image size
    // ---------------------------------------------------------------
    always_comb begin
        cw_c = r_width;
        if (r_width == '0) begin
            cw_c = DIM_W'(1);
        end else if (r_width > WIDTH_LIM) begin
            cw_c = WIDTH_LIM;
        end
        ch_c = r_height;
        if (r_height == '0) begin
            ch_c = DIM_W'(1);
        end else if (r_height > HEIGHT_LIM) begin
            ch_c = HEIGHT_LIM;
        end
    end

    assign size_prod = (2*DIM_W)'(cw_c) * (2*DIM_W)'(ch_c);
    assign total_c   = (size_prod > (2*DIM_W)'(TOTAL_CAP)) ? TOTAL_CAP
                                                           : size_prod[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_cw     <= DIM_W'(1);
            r_total  <= POS_W'(1);
        end else begin
            r_cw    <= cw_c;
            r_total <= total_c;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RLE_MODE:     r_mode   <= i_cfg_data[0];
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Control sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (i_cfg_we) begin
                    n_state = ST_SETTLE;
                end else if (div_go) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_SETTLE: begin
                n_state = i_cfg_we ? ST_SETTLE : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_cfg_we) begin
                    n_state = ST_SETTLE;
                end else if (div_last) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        run_ok       = (r_state == ST_RUN);
        div_active   = (r_state == ST_DIVIDE);
        div_load_pos = (r_state == ST_SETTLE) && !i_cfg_we;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Restoring remainder: one bit of the position per cycle.
    assign div_trial    = {r_div_rem, r_div_num[POS_W-1]};
    assign div_ge       = div_trial >= {1'b0, r_cw};
    assign div_rem_next = div_ge ? DIM_W'(div_trial - {1'b0, r_cw}) : div_trial[DIM_W-1:0];
    assign div_last     = (r_div_cnt == DIV_CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_div_row <= 1'b0;
        end else begin
            if (div_go && run_ok && !i_cfg_we) begin
                r_div_num <= n_pos;
                r_div_rem <= '0;
                r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
                r_div_row <= div_go_row;
            end else if (div_load_pos) begin
                r_div_num <= r_pos;
                r_div_rem <= '0;
                r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (div_active && !i_cfg_we) begin
                r_div_num <= {r_div_num[POS_W-2:0], 1'b0};
                r_div_rem <= div_rem_next;
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                if (div_last) begin
                    r_div_row <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stream parser
    // ---------------------------------------------------------------
    assign a_adv      = r_a_valid && (!r_b_valid || i_out_ready);
    assign o_in_ready = run_ok && (!r_a_valid || a_adv);
    assign in_fire    = i_in_valid && o_in_ready;
    assign b          = i_in_data.data_byte;

    always_comb begin
        draw_req = r_first;
        if (r_phase == PH_LITERAL) begin
            draw_req = (r_mode && (r_lit >= BYTE_W'(2))) ? BYTE_W'(2) : BYTE_W'(1);
        end
    end

    assign avail      = r_total - r_pos;
    assign draw_n     = ({{(POS_W-BYTE_W){1'b0}}, draw_req} < avail) ? draw_req
                                                                      : avail[BYTE_W-1:0];
    assign draw_pos   = r_pos + POS_W'(draw_n);
    assign pos_at_end = r_pos >= r_total;
    assign delta_mul  = 21'(r_cw) * 21'(b);
    assign next_delta = {1'b0, r_pos} + (POS_W+1)'(delta_mul) + (POS_W+1)'(r_dcol);
    assign next_eol   = {1'b0, r_pos} - (POS_W+1)'(r_col) + (POS_W+1)'(r_cw);
    assign col_sum    = (DIM_W+1)'(r_col) + (DIM_W+1)'(draw_do ? draw_n : r_dcol);
    assign col_diff   = col_sum - {1'b0, r_cw};
    assign lit_plus   = {1'b0, b} + 9'd1;

    assign addr0 = r_mode ? AW'(b[7:4]) : idx_lut[b];
    assign addr1 = AW'(b[3:0]);

    always_comb begin
        n_pos      = r_pos;
        n_col      = r_col;
        n_row_end  = r_row_end;
        n_phase    = r_phase;
        n_first    = r_first;
        n_lit      = r_lit;
        n_pad      = r_pad;
        n_dcol     = r_dcol;
        n_finished = r_finished;
        pal_we     = 1'b0;
        res_valid  = 1'b0;
        res_blank  = 1'b0;
        res_done   = 1'b0;
        res_len    = '0;
        draw_do    = 1'b0;
        col_fix    = 1'b0;
        col_row    = 1'b0;
        div_go     = 1'b0;
        div_go_row = 1'b0;

        if (in_fire) begin
            unique case (i_in_data.command)
                CMD_PAL_WRITE: pal_we = 1'b1;
                CMD_NEW_IMAGE: begin
                    n_pos      = '0;
                    n_col      = '0;
                    n_row_end  = 1'b0;
                    n_phase    = PH_FIRST;
                    n_first    = '0;
                    n_lit      = '0;
                    n_pad      = 1'b0;
                    n_dcol     = '0;
                    n_finished = 1'b0;
                end
                CMD_STREAM: begin
                    priority if (r_finished) begin
                        // Bytes after the image end are dropped.
                    end else if (pos_at_end) begin
                        n_finished = 1'b1;
                        res_valid  = 1'b1;
                        res_blank  = 1'b1;
                    end else begin
                        unique case (r_phase)
                            PH_FIRST: begin
                                n_first = b;
                                n_phase = PH_SECOND;
                            end
                            PH_SECOND: begin
                                n_phase = PH_FIRST;
                                priority if (r_first != '0) begin
                                    draw_do = 1'b1;
                                end else if (b == ESC_EOL) begin
                                    n_row_end = 1'b0;
                                    if (!r_row_end) begin
                                        if (next_eol >= (POS_W+1)'(r_total)) begin
                                            n_finished = 1'b1;
                                            res_valid  = 1'b1;
                                            res_blank  = 1'b1;
                                        end else begin
                                            n_pos = next_eol[POS_W-1:0];
                                            n_col = '0;
                                        end
                                    end
                                end else if (b == ESC_EOB) begin
                                    n_finished = 1'b1;
                                    res_valid  = 1'b1;
                                    res_blank  = 1'b1;
                                end else if (b == ESC_DELTA) begin
                                    n_phase = PH_DELTA_X;
                                end else begin
                                    n_lit   = b;
                                    // Each literal block is padded to an even byte count.
                                    n_pad   = r_mode ? lit_plus[1] : b[0];
                                    n_phase = PH_LITERAL;
                                end
                            end
                            PH_DELTA_X: begin
                                n_dcol  = b;
                                n_phase = PH_DELTA_Y;
                            end
                            PH_DELTA_Y: begin
                                n_phase   = PH_FIRST;
                                n_row_end = 1'b0;
                                if (next_delta >= (POS_W+1)'(r_total)) begin
                                    n_finished = 1'b1;
                                    res_valid  = 1'b1;
                                    res_blank  = 1'b1;
                                end else begin
                                    n_pos   = next_delta[POS_W-1:0];
                                    col_fix = 1'b1;
                                end
                            end
                            PH_LITERAL: begin
                                draw_do = 1'b1;
                                n_lit   = (r_lit > draw_req) ? r_lit - draw_req : '0;
                                if (n_lit == '0) begin
                                    n_phase = r_pad ? PH_PAD : PH_FIRST;
                                end
                            end
                            PH_PAD: begin
                                n_pad   = 1'b0;
                                n_phase = PH_FIRST;
                            end
                            default: n_phase = PH_FIRST;
                        endcase
                    end
                end
                default: ;
            endcase
        end

        if (res_blank) begin
            res_done = 1'b1;
        end

        if (draw_do) begin
            n_pos     = draw_pos;
            col_fix   = 1'b1;
            col_row   = 1'b1;
            res_valid = 1'b1;
            res_len   = draw_n;
            if (draw_pos >= r_total) begin
                n_finished = 1'b1;
            end
            res_done = (draw_pos >= r_total);
        end

        // The column stays the position modulo the width. One wrap is folded
        // here; a longer step goes to the serial remainder unit.
        if (col_fix) begin
            priority if (col_sum < {1'b0, r_cw}) begin
                n_col = col_sum[DIM_W-1:0];
                if (col_row) begin
                    n_row_end = (col_sum == '0);
                end
            end else if (col_diff < {1'b0, r_cw}) begin
                n_col = col_diff[DIM_W-1:0];
                if (col_row) begin
                    n_row_end = (col_diff == '0);
                end
            end else begin
                div_go     = 1'b1;
                div_go_row = col_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_col      <= '0;
            r_row_end  <= 1'b0;
            r_phase    <= PH_FIRST;
            r_first    <= '0;
            r_lit      <= '0;
            r_pad      <= 1'b0;
            r_dcol     <= '0;
            r_finished <= 1'b0;
        end else if (div_active && div_last && !i_cfg_we) begin
            r_col <= div_rem_next;
            if (r_div_row) begin
                r_row_end <= (div_rem_next == '0);
            end
        end else begin
            r_pos      <= n_pos;
            r_col      <= n_col;
            r_row_end  <= n_row_end;
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_lit      <= n_lit;
            r_pad      <= n_pad;
            r_dcol     <= n_dcol;
            r_finished <= n_finished;
        end
    end

    // ---------------------------------------------------------------
    // Palette memory and output queue
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal[idx_lut[i_in_data.palette_index]] <= i_in_data.palette_color;
        end
        if (res_valid) begin
            r_rd0 <= r_pal[addr0];
            r_rd1 <= r_pal[addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_a_start <= r_pos[START_W-1:0];
            r_a_len   <= res_len;
            r_a_done  <= res_done;
            r_a_blank <= res_blank;
            r_a_split <= r_mode;
        end
        if (a_adv) begin
            r_b_item.start_pixel <= r_a_start;
            r_b_item.run_length  <= r_a_len;
            r_b_item.image_done  <= r_a_done;
            r_b_item.color_even  <= r_a_blank ? '0 : r_rd0;
            if (r_a_blank || (r_a_len < BYTE_W'(2))) begin
                r_b_item.color_odd <= '0;
            end else begin
                r_b_item.color_odd <= r_a_split ? r_rd1 : r_rd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= res_valid || (r_a_valid && !a_adv);
            r_b_valid <= a_adv || (r_b_valid && !i_out_ready);
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_out_data  = r_b_item;

endmodule
